### hdl/att_pdu_event_parser_defines.svh
// Assertion macros shared by the ATT PDU event parser modules.
`ifndef ATT_PDU_EVENT_PARSER_DEFINES_SVH
`define ATT_PDU_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ATT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ATT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/att_pkg.sv
// Shared types and constants of the ATT PDU event parser.
package att_pkg;

	// ATT opcodes that the parser recognizes.
	localparam logic [7:0] OP_ERROR          = 8'h01;
	localparam logic [7:0] OP_MTU_RSP        = 8'h03;
	localparam logic [7:0] OP_FIND_INFO_RSP  = 8'h05;
	localparam logic [7:0] OP_FIND_VALUE_RSP = 8'h07;
	localparam logic [7:0] OP_BY_TYPE_RSP    = 8'h09;
	localparam logic [7:0] OP_READ_RSP       = 8'h0B;
	localparam logic [7:0] OP_GROUP_RSP      = 8'h11;
	localparam logic [7:0] OP_WRITE_RSP      = 8'h13;
	localparam logic [7:0] OP_NOTIFY         = 8'h1B;
	localparam logic [7:0] OP_INDICATE       = 8'h1D;

	// Event kinds as they appear on the result port.
	localparam logic [3:0] KIND_ERROR      = 4'd0;
	localparam logic [3:0] KIND_MTU        = 4'd1;
	localparam logic [3:0] KIND_READ       = 4'd2;
	localparam logic [3:0] KIND_BY_TYPE    = 4'd3;
	localparam logic [3:0] KIND_GROUP      = 4'd4;
	localparam logic [3:0] KIND_WRITE      = 4'd5;
	localparam logic [3:0] KIND_NOTIFY     = 4'd6;
	localparam logic [3:0] KIND_INDICATE   = 4'd7;
	localparam logic [3:0] KIND_FIND_INFO  = 4'd8;
	localparam logic [3:0] KIND_FIND_VALUE = 4'd9;
	localparam logic [3:0] KIND_UNKNOWN    = 4'd10;

	// Packet and record limits.
	localparam logic [15:0] MIN_PACKET = 16'd5;
	localparam logic [7:0]  MIN_RECORD = 8'd6;
	localparam logic [15:0] POS_MAX    = 16'hFFFF;
	localparam logic [15:0] ATT_CHANNEL_RESET = 16'd4;

	// Event queue between the parser front and the formatting back.
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

	// Classified event as it travels through the queue.
	// info holds the record bytes for a group record, else ATT bytes 1..4.
	typedef struct packed {
		logic [3:0]  kind;
		logic [11:0] link;
		logic [15:0] length;
		logic [47:0] info;
	} evt_t;

endpackage

### hdl/att_front.sv
// Parser front: takes bytes, tracks packet state and classifies events.
`include "att_pdu_event_parser_defines.svh"
module att_front import att_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        start_of_packet,
	input  logic        end_of_packet,
	input  logic [11:0] link_handle,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        evt_valid,
	output evt_t        evt
);

	logic [15:0] att_chan_q;
	logic [15:0] pos_q, len_q, chan_q;
	logic [7:0]  op_q, rsize_q, rpos_q;
	logic [31:0] fb_q;
	logic [47:0] rf_q;
	logic [11:0] link_q;

	logic        new_pkt;
	logic [15:0] p, len_b, chan_b;
	logic [7:0]  op_b, rsize_b, rpos_b;
	logic [31:0] fb_b;
	logic [47:0] rf_b;
	logic [11:0] link_b;

	logic [15:0] pos_n, len_n, chan_n;
	logic [7:0]  op_n, rsize_n, rpos_n, rp_inc;
	logic [31:0] fb_n;
	logic [47:0] rf_cur, rf_n;
	logic        grp_emit, fin_emit;
	logic [3:0]  fin_kind;

	// A start mark or an idle position opens a new packet with cleared fields.
	always_comb begin
		new_pkt = start_of_packet || (pos_q == 16'd0);
		p       = new_pkt ? 16'd0  : pos_q;
		len_b   = new_pkt ? 16'd0  : len_q;
		chan_b  = new_pkt ? 16'd0  : chan_q;
		op_b    = new_pkt ? 8'd0   : op_q;
		rsize_b = new_pkt ? 8'd0   : rsize_q;
		rpos_b  = new_pkt ? 8'd0   : rpos_q;
		fb_b    = new_pkt ? 32'd0  : fb_q;
		rf_b    = new_pkt ? 48'd0  : rf_q;
		link_b  = new_pkt ? link_handle : link_q;
	end

	// Per-byte update of the header fields and the group record tracker.
	always_comb begin
		len_n    = len_b;
		chan_n   = chan_b;
		op_n     = op_b;
		fb_n     = fb_b;
		rsize_n  = rsize_b;
		rpos_n   = rpos_b;
		rf_cur   = rf_b;
		rf_n     = rf_b;
		rp_inc   = rpos_b + 8'd1;
		grp_emit = 1'b0;
		pos_n    = p;
		if (p != POS_MAX) begin
			pos_n = p + 16'd1;
			case (p)
				16'd0: len_n[7:0]   = data_byte;
				16'd1: len_n[15:8]  = data_byte;
				16'd2: chan_n[7:0]  = data_byte;
				16'd3: chan_n[15:8] = data_byte;
				16'd4: op_n         = data_byte;
				default: begin
					case (p)
						16'd5: fb_n[7:0]   = data_byte;
						16'd6: fb_n[15:8]  = data_byte;
						16'd7: fb_n[23:16] = data_byte;
						16'd8: fb_n[31:24] = data_byte;
						default: fb_n = fb_b;
					endcase
					if (p == 16'd5) begin
						rsize_n = data_byte;
					end
					if ((op_b == OP_GROUP_RSP) && (p >= 16'd6) && (rsize_b >= MIN_RECORD)) begin
						case (rpos_b)
							8'd0: rf_cur[7:0]   = data_byte;
							8'd1: rf_cur[15:8]  = data_byte;
							8'd2: rf_cur[23:16] = data_byte;
							8'd3: rf_cur[31:24] = data_byte;
							8'd4: rf_cur[39:32] = data_byte;
							8'd5: rf_cur[47:40] = data_byte;
							default: rf_cur = rf_b;
						endcase
						if (rp_inc == rsize_b) begin
							grp_emit = ((p - 16'd4) < len_b) && (chan_b == att_chan_q);
							rpos_n   = 8'd0;
							rf_n     = 48'd0;
						end else begin
							rpos_n = rp_inc;
							rf_n   = rf_cur;
						end
					end
				end
			endcase
		end
	end

	// Packet-end classification with the per-opcode length checks.
	always_comb begin
		fin_emit = 1'b0;
		fin_kind = KIND_UNKNOWN;
		if (end_of_packet && (pos_n >= MIN_PACKET) && (chan_n == att_chan_q)
				&& (len_n != 16'd0)) begin
			case (op_n)
				OP_ERROR: begin
					fin_kind = KIND_ERROR;
					fin_emit = (len_n >= 16'd5);
				end
				OP_MTU_RSP: begin
					fin_kind = KIND_MTU;
					fin_emit = (len_n >= 16'd3);
				end
				OP_READ_RSP: begin
					fin_kind = KIND_READ;
					fin_emit = 1'b1;
				end
				OP_BY_TYPE_RSP: begin
					fin_kind = KIND_BY_TYPE;
					fin_emit = (len_n >= 16'd2);
				end
				OP_GROUP_RSP: begin
					fin_kind = KIND_GROUP;
					fin_emit = 1'b0;
				end
				OP_WRITE_RSP: begin
					fin_kind = KIND_WRITE;
					fin_emit = 1'b1;
				end
				OP_NOTIFY: begin
					fin_kind = KIND_NOTIFY;
					fin_emit = (len_n >= 16'd3);
				end
				OP_INDICATE: begin
					fin_kind = KIND_INDICATE;
					fin_emit = (len_n >= 16'd3);
				end
				OP_FIND_INFO_RSP: begin
					fin_kind = KIND_FIND_INFO;
					fin_emit = (len_n >= 16'd2);
				end
				OP_FIND_VALUE_RSP: begin
					fin_kind = KIND_FIND_VALUE;
					fin_emit = 1'b1;
				end
				default: begin
					fin_kind = KIND_UNKNOWN;
					fin_emit = 1'b1;
				end
			endcase
		end
	end

	// Event toward the queue; a group record takes precedence over packet end.
	always_comb begin
		evt_valid  = accept && (grp_emit || fin_emit);
		evt.kind   = grp_emit ? KIND_GROUP : fin_kind;
		evt.link   = link_b;
		evt.length = len_n;
		evt.info   = grp_emit ? rf_cur : {16'd0, fb_n};
	end

	// Channel register and packet state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_chan_q <= ATT_CHANNEL_RESET;
			pos_q      <= 16'd0;
			len_q      <= 16'd0;
			chan_q     <= 16'd0;
			op_q       <= 8'd0;
			fb_q       <= 32'd0;
			rsize_q    <= 8'd0;
			rpos_q     <= 8'd0;
			rf_q       <= 48'd0;
			link_q     <= 12'd0;
		end else begin
			if (cfg_we) begin
				att_chan_q <= cfg_wdata;
			end
			if (accept) begin
				pos_q   <= end_of_packet ? 16'd0 : pos_n;
				len_q   <= len_n;
				chan_q  <= chan_n;
				op_q    <= op_n;
				fb_q    <= fb_n;
				rsize_q <= rsize_n;
				rpos_q  <= rpos_n;
				rf_q    <= rf_n;
				link_q  <= link_b;
			end
		end
	end

endmodule

### hdl/att_evq.sv
// Short event queue between the parser front and the formatting back.
`include "att_pdu_event_parser_defines.svh"
module att_evq import att_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  evt_t  wr_data,
	input  logic  rd,
	output evt_t  rd_data,
	output logic  full,
	output logic  empty
);

	evt_t              mem_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0] wptr_q, rptr_q;
	logic [EVQ_AW:0]   count_q;

	assign full    = (count_q == EVQ_AW'(0) + (EVQ_AW+1)'(EVQ_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + EVQ_AW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + EVQ_AW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + (EVQ_AW+1)'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - (EVQ_AW+1)'(1);
			end
		end
	end

	`ATT_ASSERT_IMP(a_no_overflow, wr, !full || rd, "event written into a full queue")
	`ATT_ASSERT_IMP(a_no_underflow, rd, !empty, "event read from an empty queue")
	`ATT_ASSERT_NXT(a_count_up, wr && !rd, count_q == $past(count_q) + (EVQ_AW+1)'(1), "fill count did not rise on a write")
	`ATT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= (EVQ_AW+1)'(EVQ_DEPTH), "fill count beyond queue depth")

endmodule

### hdl/att_back.sv
// Formatting back: expands queued events into result fields and holds the result.
module att_back import att_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  evt_t        q_data,
	output logic        q_rd,
	input  logic        pop,
	output logic        empty,
	output logic [3:0]  event_kind,
	output logic [11:0] event_link,
	output logic [15:0] attr_handle,
	output logic [1:0]  data_offset,
	output logic [15:0] data_len,
	output logic [15:0] peer_mtu,
	output logic [15:0] group_start,
	output logic [15:0] group_end,
	output logic [15:0] group_uuid,
	output logic        confirm_request
);

	logic        out_valid_q;
	logic [15:0] handle_c, length_c, mtu_c;
	logic [1:0]  offset_c;
	logic [47:0] rec_c;
	logic        confirm_c;

	// Take the queue head when the result register is free or being emptied.
	assign q_rd  = !q_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	// Per-kind field selection.
	always_comb begin
		handle_c  = 16'd0;
		mtu_c     = 16'd0;
		rec_c     = 48'd0;
		confirm_c = 1'b0;
		offset_c  = 2'd1;
		length_c  = q_data.length - 16'd1;
		case (q_data.kind)
			KIND_ERROR: begin
				handle_c = q_data.info[23:8];
			end
			KIND_MTU: begin
				mtu_c    = q_data.info[15:0];
				length_c = 16'd2;
			end
			KIND_GROUP: begin
				rec_c = q_data.info;
			end
			KIND_WRITE: begin
				offset_c = 2'd0;
				length_c = 16'd0;
			end
			KIND_NOTIFY, KIND_INDICATE: begin
				handle_c  = q_data.info[15:0];
				offset_c  = 2'd3;
				length_c  = q_data.length - 16'd3;
				confirm_c = (q_data.kind == KIND_INDICATE);
			end
			KIND_UNKNOWN: begin
				offset_c = 2'd0;
				length_c = q_data.length;
			end
			default: begin
				offset_c = 2'd1;
			end
		endcase
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			event_kind      <= q_data.kind;
			event_link      <= q_data.link;
			attr_handle     <= handle_c;
			data_offset     <= offset_c;
			data_len        <= length_c;
			peer_mtu        <= mtu_c;
			group_start     <= rec_c[15:0];
			group_end       <= rec_c[31:16];
			group_uuid      <= rec_c[47:32];
			confirm_request <= confirm_c;
		end
	end

endmodule

### hdl/att_pdu_event_parser.sv
// Top level of the ATT PDU event parser.
// The parser takes one ACL payload byte per clock while full is low (L2CAP
// header first) and classifies the ATT PDU it carries; each byte is parsed in
// the cycle it is accepted, and any event it causes is written into a four-entry
// event queue on that same edge. The oldest event reaches the result ports from
// the queue through a single result register, once that register is empty or
// being popped. full rises only when the four queue entries and the result
// register all hold events that have not been popped. Packet end gives at most
// one event; a read-by-group-type response instead gives one event per complete
// record. The user must write the channel register through cfg_we and cfg_wdata
// only while idle; the block itself does not enforce it.
module att_pdu_event_parser import att_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_of_packet,
	input  logic        end_of_packet,
	input  logic [11:0] link_handle,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  event_kind,
	output logic [11:0] event_link,
	output logic [15:0] attr_handle,
	output logic [1:0]  data_offset,
	output logic [15:0] data_len,
	output logic [15:0] peer_mtu,
	output logic [15:0] group_start,
	output logic [15:0] group_end,
	output logic [15:0] group_uuid,
	output logic        confirm_request,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic accept;
	logic evt_valid;
	evt_t evt;
	evt_t q_data;
	logic q_full, q_empty, q_rd;

	// A byte is taken whenever the event queue has room.
	assign full   = q_full;
	assign accept = push && !q_full;

	// Byte parser and classifier.
	att_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.start_of_packet (start_of_packet),
		.end_of_packet   (end_of_packet),
		.link_handle     (link_handle),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.evt_valid       (evt_valid),
		.evt             (evt)
	);

	// Event queue.
	att_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (evt_valid),
		.wr_data (evt),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Result formatting and output register.
	att_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_data),
		.q_rd            (q_rd),
		.pop             (pop),
		.empty           (empty),
		.event_kind      (event_kind),
		.event_link      (event_link),
		.attr_handle     (attr_handle),
		.data_offset     (data_offset),
		.data_len        (data_len),
		.peer_mtu        (peer_mtu),
		.group_start     (group_start),
		.group_end       (group_end),
		.group_uuid      (group_uuid),
		.confirm_request (confirm_request)
	);

endmodule
